// ----- design/rrp_pkg.sv -----
`default_nettype none
package rrp_pkg;

  localparam int BLOCK_BYTES = 24;
  localparam int MAX_BLOCKS  = 31;
  localparam int HEAD_BYTES  = 8;
  localparam int LEN_W       = 19;
  localparam int POS_W       = $clog2(BLOCK_BYTES);
  localparam int CNT_W       = 5;
  localparam int BLK_W       = (BLOCK_BYTES - 1) * 8;

  localparam logic [1:0] VERSION = 2'd2;
  localparam logic [7:0] PT_RR   = 8'hc9;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_HEAD  = 2'd1,
    PH_BLOCK = 2'd2,
    PH_SKIP  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_BLOCK   = 3'd0,
    ST_DONE    = 3'd1,
    ST_SHORT   = 3'd2,
    ST_BAD_HDR = 3'd3,
    ST_COUNT   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             start_of_packet;
    logic [LEN_W-1:0] bytes_available;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        reporter_ssrc;
    logic [31:0]        source_ssrc;
    logic [7:0]         fraction_lost;
    logic signed [23:0] cumulative_lost;
    logic [31:0]        highest_sequence;
    logic [31:0]        interarrival_jitter;
    logic [31:0]        last_sr_time;
    logic [31:0]        delay_since_sr;
    status_t            status;
    logic               last_of_report;
  } result_t;

endpackage
`default_nettype wire

// ----- design/rrp_channels.sv -----
`default_nettype none
interface rrp_in_if;
  logic                       valid;
  logic                       ready;
  logic [7:0]                 data_byte;
  logic                       start_of_packet;
  logic [rrp_pkg::LEN_W-1:0]  bytes_available;

  modport source (output valid, data_byte, start_of_packet, bytes_available, input ready);
  modport sink   (input valid, data_byte, start_of_packet, bytes_available, output ready);
endinterface

interface rrp_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        reporter_ssrc;
  logic [31:0]        source_ssrc;
  logic [7:0]         fraction_lost;
  logic signed [23:0] cumulative_lost;
  logic [31:0]        highest_sequence;
  logic [31:0]        interarrival_jitter;
  logic [31:0]        last_sr_time;
  logic [31:0]        delay_since_sr;
  logic [2:0]         status;
  logic               last_of_report;

  modport source (output valid, reporter_ssrc, source_ssrc, fraction_lost, cumulative_lost,
                  highest_sequence, interarrival_jitter, last_sr_time, delay_since_sr,
                  status, last_of_report,
                  input ready);
  modport sink   (input valid, reporter_ssrc, source_ssrc, fraction_lost, cumulative_lost,
                  highest_sequence, interarrival_jitter, last_sr_time, delay_since_sr,
                  status, last_of_report,
                  output ready);
endinterface
`default_nettype wire

// ----- design/rtcp_receiver_report_parser_unit.sv -----
// Path: an accepted byte is held in the input register and feeds the parse logic; any result
// it causes is then loaded into the output register.
// Throughput: one byte per cycle while the output is not stalled, set by the parse step between
// the input register and the output register; a stalled output holds the input stage.
// Reset (synchronous, rst_n low): parser idle, waiting for a start byte; both stages empty.
`default_nettype none
module rtcp_receiver_report_parser_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rrp_in_if.sink     in_ch,
  rrp_out_if.source  out_ch
);

  logic              item_valid;
  rrp_pkg::in_item_t item;
  logic              out_free;
  logic              adv;
  logic              res_valid;
  rrp_pkg::result_t  res;

  assign adv = item_valid && out_free;

  rrp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  rrp_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  rrp_out_reg u_out_reg (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (adv && res_valid),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

// ----- design/rrp_in_reg.sv -----
`default_nettype none
module rrp_in_reg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rrp_in_if.sink           in_ch,
  input  wire logic        adv,
  output logic             item_valid,
  output rrp_pkg::in_item_t item
);

  logic              valid_r, valid_nxt;
  rrp_pkg::in_item_t item_r;
  logic              take;

  assign in_ch.ready = !valid_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.data_byte       <= in_ch.data_byte;
      item_r.start_of_packet <= in_ch.start_of_packet;
      item_r.bytes_available <= in_ch.bytes_available;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

// ----- design/rrp_parse_core.sv -----
`default_nettype none
module rrp_parse_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire rrp_pkg::in_item_t item,
  output logic                   res_valid,
  output rrp_pkg::result_t       res
);

  rrp_pkg::phase_t                phase_r, phase_nxt;
  logic [rrp_pkg::POS_W-1:0]      pos_r, pos_nxt;
  logic [rrp_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [rrp_pkg::CNT_W-1:0]      idx_r, idx_nxt;
  logic [rrp_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic [31:0]                    ssrc_r, ssrc_nxt;
  logic [7:0]                     hb0_r, hb0_nxt;
  logic [rrp_pkg::BLK_W-1:0]      blk_r, blk_nxt;

  logic [31:0]                    ssrc_sh;
  logic [16:0]                    f_inc;
  logic [rrp_pkg::LEN_W-1:0]      rep_len;
  logic [rrp_pkg::LEN_W-1:0]      need_len;
  logic [rrp_pkg::CNT_W-1:0]      hdr_cnt;
  logic [rrp_pkg::CNT_W-1:0]      idx_inc;
  logic [rrp_pkg::BLK_W+7:0]      full_blk;

  // header fields as seen on byte 3
  assign ssrc_sh  = {ssrc_r[23:0], item.data_byte};
  assign f_inc    = {1'b0, ssrc_sh[15:0]} + 17'd1;
  assign rep_len  = {f_inc, 2'b00};
  assign hdr_cnt  = hb0_r[7:3];
  assign need_len = rrp_pkg::LEN_W'(rrp_pkg::HEAD_BYTES)
                  + rrp_pkg::LEN_W'(hdr_cnt) * rrp_pkg::LEN_W'(rrp_pkg::BLOCK_BYTES);
  assign idx_inc  = idx_r + 1'b1;
  // block byte 0 sits at the top
  assign full_blk = {blk_r, item.data_byte};

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    ssrc_nxt  = ssrc_r;
    hb0_nxt   = hb0_r;
    blk_nxt   = blk_r;
    res_valid = 1'b0;
    res       = '0;

    if (item.start_of_packet) begin
      // a start always restarts, dropping any report in flight
      phase_nxt = rrp_pkg::PH_HEAD;
      hb0_nxt   = item.data_byte;
      len_nxt   = item.bytes_available;
      ssrc_nxt  = '0;
      pos_nxt   = rrp_pkg::POS_W'(1);
      cnt_nxt   = '0;
      idx_nxt   = '0;
    end else begin
      unique case (phase_r)
        rrp_pkg::PH_HEAD: begin
          ssrc_nxt = ssrc_sh;
          if (pos_r == rrp_pkg::POS_W'(3)) begin
            len_nxt = rep_len;
            cnt_nxt = hdr_cnt;
            pos_nxt = rrp_pkg::POS_W'(4);
            priority if (rep_len < rrp_pkg::LEN_W'(rrp_pkg::HEAD_BYTES) || rep_len > len_r) begin
              res.status = rrp_pkg::ST_SHORT;
              res_valid  = 1'b1;
            end else if (hb0_r[1:0] != rrp_pkg::VERSION || ssrc_sh[23:16] != rrp_pkg::PT_RR) begin
              res.status = rrp_pkg::ST_BAD_HDR;
              res_valid  = 1'b1;
            end else if (need_len > rep_len
                         || hdr_cnt > rrp_pkg::CNT_W'(rrp_pkg::MAX_BLOCKS)) begin
              res.status = rrp_pkg::ST_COUNT;
              res_valid  = 1'b1;
            end else begin
              res_valid = 1'b0;
            end
            if (res_valid) begin
              res.last_of_report = 1'b1;
              phase_nxt          = rrp_pkg::PH_SKIP;
            end
          end else if (pos_r == rrp_pkg::POS_W'(7)) begin
            if (cnt_r == '0) begin
              res_valid          = 1'b1;
              res.reporter_ssrc  = ssrc_sh;
              res.status         = rrp_pkg::ST_DONE;
              res.last_of_report = 1'b1;
              phase_nxt          = rrp_pkg::PH_SKIP;
            end else begin
              phase_nxt = rrp_pkg::PH_BLOCK;
              pos_nxt   = '0;
              idx_nxt   = '0;
            end
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
        rrp_pkg::PH_BLOCK: begin
          blk_nxt = full_blk[rrp_pkg::BLK_W-1:0];
          if (pos_r != rrp_pkg::POS_W'(rrp_pkg::BLOCK_BYTES - 1)) begin
            pos_nxt = pos_r + 1'b1;
          end else begin
            res_valid               = 1'b1;
            res.reporter_ssrc       = ssrc_r;
            res.source_ssrc         = full_blk[191:160];
            res.fraction_lost       = full_blk[159:152];
            res.cumulative_lost     = full_blk[151:128];
            res.highest_sequence    = full_blk[127:96];
            res.interarrival_jitter = full_blk[95:64];
            res.last_sr_time        = full_blk[63:32];
            res.delay_since_sr      = full_blk[31:0];
            res.status              = rrp_pkg::ST_BLOCK;
            pos_nxt                 = '0;
            idx_nxt                 = idx_inc;
            if (idx_inc >= cnt_r) begin
              res.last_of_report = 1'b1;
              phase_nxt          = rrp_pkg::PH_SKIP;
            end
          end
        end
        rrp_pkg::PH_IDLE, rrp_pkg::PH_SKIP: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rrp_pkg::PH_IDLE;
      pos_r   <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      len_r  <= len_nxt;
      ssrc_r <= ssrc_nxt;
      hb0_r  <= hb0_nxt;
      blk_r  <= blk_nxt;
    end
  end

  a_block_in_block_phase: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.status == rrp_pkg::ST_BLOCK |-> phase_r == rrp_pkg::PH_BLOCK)
    else $error("block item outside block phase");

  a_last_goes_skip: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.last_of_report |=> phase_r == rrp_pkg::PH_SKIP)
    else $error("final item did not end the report");

  a_only_blocks_continue: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.last_of_report |-> res.status == rrp_pkg::ST_BLOCK)
    else $error("non-block item without last flag");

  a_error_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.status == rrp_pkg::ST_SHORT || res.status == rrp_pkg::ST_BAD_HDR
                  || res.status == rrp_pkg::ST_COUNT)
    |-> res.reporter_ssrc == '0 && res.source_ssrc == '0 && res.delay_since_sr == '0)
    else $error("error item carries payload");

endmodule
`default_nettype wire

// ----- design/rrp_out_reg.sv -----
`default_nettype none
module rrp_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire rrp_pkg::result_t res,
  output logic                  free,
  rrp_out_if.source             out_ch
);

  logic             valid_r, valid_nxt;
  rrp_pkg::result_t res_r;

  assign free = !valid_r || out_ch.ready;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid               = valid_r;
  assign out_ch.reporter_ssrc       = res_r.reporter_ssrc;
  assign out_ch.source_ssrc         = res_r.source_ssrc;
  assign out_ch.fraction_lost       = res_r.fraction_lost;
  assign out_ch.cumulative_lost     = res_r.cumulative_lost;
  assign out_ch.highest_sequence    = res_r.highest_sequence;
  assign out_ch.interarrival_jitter = res_r.interarrival_jitter;
  assign out_ch.last_sr_time        = res_r.last_sr_time;
  assign out_ch.delay_since_sr      = res_r.delay_since_sr;
  assign out_ch.status              = res_r.status;
  assign out_ch.last_of_report      = res_r.last_of_report;

endmodule
`default_nettype wire
